// ===== sv/qsp_pkg.sv =====
// Package with the constants, state codes and interface structs of the partition engine.
`timescale 1ns / 1ps

package qsp_pkg;

  // Capacity of the item store and width of a sort key.
  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 32;

  // Fixed field widths.
  localparam int TAG_W  = 6;
  localparam int RANK_W = 6;

  // Derived widths: store address, item count and window positions.
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int POS_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int WORD_W = TAG_W + KEY_BITS;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_PIV_RD,
    ST_PIV_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_WR,
    ST_FIN_RD,
    ST_FIN_WA,
    ST_FIN_WB,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // Request from the sequencer to the item store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // One result item handed from the sequencer to the output register.
  typedef struct packed {
    logic                load;
    logic [TAG_W-1:0]    tag;
    logic [KEY_BITS-1:0] key;
    logic                last;
    logic                overflow;
  } emit_t;

endpackage

// ===== sv/qsp_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module qsp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== sv/qsp_ctrl.sv =====
// Sequencer that loads the item store, runs the quickselect rounds and reads out the result.
`timescale 1ns / 1ps

module qsp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [qsp_pkg::TAG_W-1:0]     tag_i,
  input  logic signed [qsp_pkg::KEY_BITS-1:0] key_i,
  input  logic                          last_i,
  input  logic [qsp_pkg::RANK_W-1:0]    target_rank_i,
  output qsp_pkg::ram_req_t             ram_req_o,
  input  logic [qsp_pkg::WORD_W-1:0]    rdata_a_i,
  input  logic [qsp_pkg::WORD_W-1:0]    rdata_b_i,
  output qsp_pkg::emit_t                emit_o,
  input  logic                          out_free_i
);

  qsp_pkg::state_e state_q, state_d;

  logic [qsp_pkg::CNT_W-1:0]  count_q, count_d;
  logic [qsp_pkg::CNT_W-1:0]  emit_q, emit_d;
  logic                       dropped_q, dropped_d;
  logic [qsp_pkg::POS_W-1:0]  ws_q, ws_d;
  logic [qsp_pkg::POS_W-1:0]  we_q, we_d;
  logic [qsp_pkg::POS_W-1:0]  rank_q, rank_d;
  logic [qsp_pkg::POS_W-1:0]  scan_q, scan_d;
  logic [qsp_pkg::POS_W-1:0]  bnd_q, bnd_d;
  logic [qsp_pkg::WORD_W-1:0] piv_q, piv_d;

  logic [qsp_pkg::POS_W-1:0] size;
  logic [qsp_pkg::POS_W-1:0] mid_pos;
  logic [qsp_pkg::POS_W-1:0] scan_pos;
  logic [qsp_pkg::POS_W-1:0] swap_pos;
  logic [qsp_pkg::POS_W-1:0] bnd_pos;
  logic                      window_done;
  logic                      scan_done;
  logic                      key_less;
  logic                      has_room;
  logic                      emit_last;

  // Window arithmetic shared by the state and output logic.
  assign size        = we_q - ws_q;
  assign mid_pos     = ws_q + (size >> 1);
  assign scan_pos    = ws_q + scan_q;
  assign swap_pos    = ws_q + bnd_q + qsp_pkg::POS_W'(1);
  assign bnd_pos     = ws_q + bnd_q;
  assign window_done = (we_q <= ws_q) || (size <= qsp_pkg::POS_W'(1));
  assign scan_done   = (scan_q >= size);
  assign has_room    = (count_q < qsp_pkg::CNT_W'(qsp_pkg::MAX_ITEMS));
  assign emit_last   = ((emit_q + qsp_pkg::CNT_W'(1)) == count_q);

  // Strict signed less-than of the scanned key against the pivot key.
  assign key_less = $signed(rdata_a_i[qsp_pkg::KEY_BITS-1:0]) <
                    $signed(piv_q[qsp_pkg::KEY_BITS-1:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qsp_pkg::ST_LOAD: begin
        if (in_valid_i && last_i) begin
          state_d = qsp_pkg::ST_CHECK;
        end
      end
      qsp_pkg::ST_CHECK: begin
        state_d = window_done ? qsp_pkg::ST_EMIT_RD : qsp_pkg::ST_PIV_RD;
      end
      qsp_pkg::ST_PIV_RD:  state_d = qsp_pkg::ST_PIV_WR;
      qsp_pkg::ST_PIV_WR:  state_d = qsp_pkg::ST_SCAN_RD;
      qsp_pkg::ST_SCAN_RD: begin
        state_d = scan_done ? qsp_pkg::ST_FIN_RD : qsp_pkg::ST_SCAN_EV;
      end
      qsp_pkg::ST_SCAN_EV: begin
        state_d = key_less ? qsp_pkg::ST_SCAN_WR : qsp_pkg::ST_SCAN_RD;
      end
      qsp_pkg::ST_SCAN_WR: state_d = qsp_pkg::ST_SCAN_RD;
      qsp_pkg::ST_FIN_RD:  state_d = qsp_pkg::ST_FIN_WA;
      qsp_pkg::ST_FIN_WA:  state_d = qsp_pkg::ST_FIN_WB;
      qsp_pkg::ST_FIN_WB: begin
        state_d = (bnd_q == rank_q) ? qsp_pkg::ST_EMIT_RD : qsp_pkg::ST_CHECK;
      end
      qsp_pkg::ST_EMIT_RD: state_d = qsp_pkg::ST_EMIT_LD;
      qsp_pkg::ST_EMIT_LD: begin
        if (out_free_i) begin
          state_d = emit_last ? qsp_pkg::ST_LOAD : qsp_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = qsp_pkg::ST_LOAD;
    endcase
  end

  // Store requests, result items and register updates for each state.
  always_comb begin
    ram_req_o   = '0;
    emit_o      = '0;
    in_stall_o  = (state_q != qsp_pkg::ST_LOAD);
    count_d     = count_q;
    emit_d      = emit_q;
    dropped_d   = dropped_q;
    ws_d        = ws_q;
    we_d        = we_q;
    rank_d      = rank_q;
    scan_d      = scan_q;
    bnd_d       = bnd_q;
    piv_d       = piv_q;

    emit_o.tag      = rdata_a_i[qsp_pkg::WORD_W-1:qsp_pkg::KEY_BITS];
    emit_o.key      = rdata_a_i[qsp_pkg::KEY_BITS-1:0];
    emit_o.last     = emit_last;
    emit_o.overflow = dropped_q;

    unique case (state_q)
      qsp_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          if (has_room) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = count_q[qsp_pkg::ADDR_W-1:0];
            ram_req_o.wdata = {tag_i, key_i};
            count_d         = count_q + qsp_pkg::CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            ws_d   = '0;
            we_d   = qsp_pkg::POS_W'(count_d);
            rank_d = qsp_pkg::POS_W'(target_rank_i);
          end
        end
      end
      qsp_pkg::ST_CHECK: begin
      end
      qsp_pkg::ST_PIV_RD: begin
        // Fetch the middle item and the window front.
        ram_req_o.re      = 1'b1;
        ram_req_o.raddr_a = mid_pos[qsp_pkg::ADDR_W-1:0];
        ram_req_o.raddr_b = ws_q[qsp_pkg::ADDR_W-1:0];
        scan_d            = qsp_pkg::POS_W'(1);
        bnd_d             = '0;
      end
      qsp_pkg::ST_PIV_WR: begin
        // The pivot lives in a register; the front slot is rewritten at placement.
        piv_d           = rdata_a_i;
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = mid_pos[qsp_pkg::ADDR_W-1:0];
        ram_req_o.wdata = rdata_b_i;
      end
      qsp_pkg::ST_SCAN_RD: begin
        if (!scan_done) begin
          ram_req_o.re      = 1'b1;
          ram_req_o.raddr_a = scan_pos[qsp_pkg::ADDR_W-1:0];
          ram_req_o.raddr_b = swap_pos[qsp_pkg::ADDR_W-1:0];
        end
      end
      qsp_pkg::ST_SCAN_EV: begin
        if (key_less) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = swap_pos[qsp_pkg::ADDR_W-1:0];
          ram_req_o.wdata = rdata_a_i;
        end else begin
          scan_d = scan_q + qsp_pkg::POS_W'(1);
        end
      end
      qsp_pkg::ST_SCAN_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = scan_pos[qsp_pkg::ADDR_W-1:0];
        ram_req_o.wdata = rdata_b_i;
        bnd_d           = bnd_q + qsp_pkg::POS_W'(1);
        scan_d          = scan_q + qsp_pkg::POS_W'(1);
      end
      qsp_pkg::ST_FIN_RD: begin
        ram_req_o.re      = 1'b1;
        ram_req_o.raddr_a = bnd_pos[qsp_pkg::ADDR_W-1:0];
      end
      qsp_pkg::ST_FIN_WA: begin
        // Move the last smaller item to the front unless the pivot stays there.
        if (bnd_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = ws_q[qsp_pkg::ADDR_W-1:0];
          ram_req_o.wdata = rdata_a_i;
        end
      end
      qsp_pkg::ST_FIN_WB: begin
        // Place the pivot and narrow the window toward the wanted rank.
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = bnd_pos[qsp_pkg::ADDR_W-1:0];
        ram_req_o.wdata = piv_q;
        if (bnd_q > rank_q) begin
          we_d = bnd_pos;
        end else if (bnd_q < rank_q) begin
          ws_d   = swap_pos;
          rank_d = rank_q - bnd_q - qsp_pkg::POS_W'(1);
        end
      end
      qsp_pkg::ST_EMIT_RD: begin
        ram_req_o.re      = 1'b1;
        ram_req_o.raddr_a = emit_q[qsp_pkg::ADDR_W-1:0];
      end
      qsp_pkg::ST_EMIT_LD: begin
        emit_o.load = out_free_i;
        if (out_free_i) begin
          if (emit_last) begin
            emit_d    = '0;
            count_d   = '0;
            dropped_d = 1'b0;
          end else begin
            emit_d = emit_q + qsp_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qsp_pkg::ST_LOAD;
      count_q   <= '0;
      emit_q    <= '0;
      dropped_q <= 1'b0;
      ws_q      <= '0;
      we_q      <= '0;
      rank_q    <= '0;
      scan_q    <= '0;
      bnd_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      emit_q    <= emit_d;
      dropped_q <= dropped_d;
      ws_q      <= ws_d;
      we_q      <= we_d;
      rank_q    <= rank_d;
      scan_q    <= scan_d;
      bnd_q     <= bnd_d;
    end
  end

  // Pivot register.
  always_ff @(posedge clk_i) begin
    piv_q <= piv_d;
  end

endmodule

// ===== sv/quickselect_partition_engine_unit.sv =====
// Top level of the quickselect partition engine: item store, sequencer and output register.
//
//   channel  direction  handshake              fields
//   in       input      in_valid_i/in_stall_o  tag_i, key_i, last_i, target_rank_i
//   out      output     out_valid_o/out_stall_i out_tag_o, out_key_o, out_last_o, overflow_o
//
// Loading takes one item per cycle into a one-write, two-read store of MAX_ITEMS entries.
// A select round reads the middle item as pivot, reads and compares each scanned item,
// with a swap write when it moves below the pivot, then closes the scan and places the
// pivot. A search that stops on a small window passes the check state once more.
// Read-out reads each item and loads it into the output register once that is free.
// Reset is asynchronous and clears control state; the store is not cleared.
// A stalled result holds in the output register; loading of the next set starts while
// the final result of a set still waits there.
`timescale 1ns / 1ps

module quickselect_partition_engine_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [qsp_pkg::TAG_W-1:0]           tag_i,
  input  logic signed [qsp_pkg::KEY_BITS-1:0] key_i,
  input  logic                                last_i,
  input  logic [qsp_pkg::RANK_W-1:0]          target_rank_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [qsp_pkg::TAG_W-1:0]           out_tag_o,
  output logic signed [qsp_pkg::KEY_BITS-1:0] out_key_o,
  output logic                                out_last_o,
  output logic                                overflow_o
);

  qsp_pkg::ram_req_t          ram_req;
  qsp_pkg::emit_t             emit;
  logic [qsp_pkg::WORD_W-1:0] rdata_a;
  logic [qsp_pkg::WORD_W-1:0] rdata_b;
  logic                       out_free;

  logic                          out_valid_q, out_valid_d;
  logic [qsp_pkg::TAG_W-1:0]     out_tag_q;
  logic [qsp_pkg::KEY_BITS-1:0]  out_key_q;
  logic                          out_last_q;
  logic                          out_ovf_q;

  // Item store holding tag and key of every loaded item.
  qsp_ram #(
    .DEPTH (qsp_pkg::MAX_ITEMS),
    .WIDTH (qsp_pkg::WORD_W)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .re_i      (ram_req.re),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Sequencer for loading, partition rounds and read-out.
  qsp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tag_i         (tag_i),
    .key_i         (key_i),
    .last_i        (last_i),
    .target_rank_i (target_rank_i),
    .ram_req_o     (ram_req),
    .rdata_a_i     (rdata_a),
    .rdata_b_i     (rdata_b),
    .emit_o        (emit),
    .out_free_i    (out_free)
  );

  // The output register can take a new item when empty or when its item leaves.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = emit.load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, loaded only with a new item.
  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_tag_q <= emit.tag;
      out_key_q <= emit.key;
      out_last_q <= emit.last;
      out_ovf_q <= emit.overflow;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tag_o   = out_tag_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

  // The sequencer never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.load |-> out_free)
    else $error("result loaded into a full, stalled output register");

  // Loading and read-out never happen in the same cycle.
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !emit.load)
    else $error("item accepted while a result is being read out");

  // The store is never written and read in the same cycle.
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> !ram_req.re)
    else $error("store written and read in the same cycle");

endmodule
